// ===== rtl/first_fit_block_allocator_core_macros.svh =====
// assertion macros used by the allocator back end
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define FFBA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FFBA_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FFBA_ASSERT(name, prop, msg)
`define FFBA_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ===== rtl/ffba_pkg.sv =====
// types and codes shared by the allocator modules
package ffba_pkg;

	localparam int BLK_W = 16;
	localparam int LEN_W = 17;
	localparam int OFF_W = 40;
	localparam int BB_W = 21;
	localparam int BB6_W = 15;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = 2'd1;

	localparam logic [1:0] FN_ALLOC = 2'd0;
	localparam logic [1:0] FN_FREE = 2'd1;
	localparam logic [1:0] FN_FREE_ALL = 2'd2;

	localparam logic [1:0] OP_ANSWER = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE = 2'd2;
	localparam logic [1:0] OP_FREE_ALL = 2'd3;

	localparam logic [2:0] ST_ALLOCATED = 3'd0;
	localparam logic [2:0] ST_FREED = 3'd1;
	localparam logic [2:0] ST_ALL_FREED = 3'd2;
	localparam logic [2:0] ST_NO_MEM = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL = 3'd4;
	localparam logic [2:0] ST_RANGE = 3'd5;
	localparam logic [2:0] ST_MISALIGNED = 3'd6;
	localparam logic [2:0] ST_NOT_ALLOC = 3'd7;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] status;
		logic [LEN_W-1:0] arg;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] blocks;
	} res_t;

	typedef struct packed {
		logic [BLK_W-1:0] start;
		logic [LEN_W-1:0] len;
	} ext_t;

endpackage

// ===== rtl/ffba_ram.sv =====
// generic single write port ram with registered read
module ffba_ram #(
	parameter int W = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/ffba_queue.sv =====
// two entry queue, used for commands and for results
module ffba_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

// ===== rtl/ffba_front.sv =====
// front end: request intake, block division and classification
module ffba_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [1:0]                        func,
	input  logic [ffba_pkg::OFF_W-1:0]        request_bytes,
	input  logic [ffba_pkg::OFF_W-1:0]        release_offset,
	input  logic [ffba_pkg::BB6_W-1:0]        bb6,
	input  logic [ffba_pkg::LEN_W-1:0]        pool,
	output logic                              cq_push,
	output ffba_pkg::cmd_t                    cq_cmd,
	input  logic                              cq_full
);

	localparam int DVD_W = ffba_pkg::OFF_W - 6;
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV = 2'd1;
	localparam logic [1:0] F_CLASS = 2'd2;
	localparam logic [5:0] LAST_STEP = 6'(DVD_W - 1);

	logic [1:0] state_q;
	logic [1:0] func_q;
	logic [ffba_pkg::OFF_W-1:0] off_q;
	logic [DVD_W-1:0] dvd_q;
	logic [ffba_pkg::BB6_W-1:0] rem_q;
	logic [5:0] cnt_q;
	logic [ffba_pkg::BB6_W:0] trial;
	logic ge;
	logic [ffba_pkg::BB6_W-1:0] rem_n;
	logic [ffba_pkg::OFF_W-1:0] dec;
	logic [31:0] lim_prod;
	logic [ffba_pkg::OFF_W-1:0] limit;

	assign full = (state_q != F_IDLE);
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge = trial >= {1'b0, bb6};
	assign rem_n = ge ? ffba_pkg::BB6_W'(trial - {1'b0, bb6}) : trial[ffba_pkg::BB6_W-1:0];
	assign dec = (request_bytes == '0) ? '0 : request_bytes - 40'd1;
	assign lim_prod = pool * bb6;
	assign limit = {2'b00, lim_prod, 6'b000000};
	assign cq_push = (state_q == F_CLASS) && !cq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			func_q <= '0;
			off_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						func_q <= func;
						off_q <= release_offset;
						dvd_q <= (func == ffba_pkg::FN_ALLOC) ? dec[ffba_pkg::OFF_W-1:6]
							: release_offset[ffba_pkg::OFF_W-1:6];
						rem_q <= '0;
						cnt_q <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					dvd_q <= {dvd_q[DVD_W-2:0], ge};
					rem_q <= rem_n;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == LAST_STEP) begin
						state_q <= F_CLASS;
					end
				end
				F_CLASS: begin
					if (!cq_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_comb begin
		cq_cmd.op = ffba_pkg::OP_ANSWER;
		cq_cmd.status = ffba_pkg::ST_RANGE;
		cq_cmd.arg = '0;
		case (func_q)
			ffba_pkg::FN_ALLOC: begin
				cq_cmd.op = ffba_pkg::OP_ALLOC;
				if (dvd_q[DVD_W-1:ffba_pkg::BLK_W] == '0) begin
					cq_cmd.arg = {1'b0, dvd_q[ffba_pkg::BLK_W-1:0]} + 17'd1;
				end else begin
					cq_cmd.arg = '1;
				end
			end
			ffba_pkg::FN_FREE: begin
				if (off_q >= limit) begin
					cq_cmd.status = ffba_pkg::ST_RANGE;
				end else if (off_q[5:0] != 6'd0 || rem_q != '0) begin
					cq_cmd.status = ffba_pkg::ST_MISALIGNED;
				end else begin
					cq_cmd.op = ffba_pkg::OP_FREE;
					cq_cmd.arg = {1'b0, dvd_q[ffba_pkg::BLK_W-1:0]};
				end
			end
			ffba_pkg::FN_FREE_ALL: begin
				cq_cmd.op = ffba_pkg::OP_FREE_ALL;
			end
			default: begin
				cq_cmd.status = ffba_pkg::ST_RANGE;
			end
		endcase
	end

endmodule

// ===== rtl/ffba_back.sv =====
// back end: free extent and live allocation table sequencer
`include "first_fit_block_allocator_core_macros.svh"
module ffba_back #(
	parameter int MAX_LIVE = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       init,
	input  logic [ffba_pkg::BB6_W-1:0] bb6,
	input  logic [ffba_pkg::LEN_W-1:0] pool,
	input  logic                       cmd_valid,
	input  ffba_pkg::cmd_t             cmd,
	output logic                       cmd_pop,
	input  logic                       res_full,
	output logic                       res_push,
	output ffba_pkg::res_t             res
);

	localparam int FD = MAX_LIVE + 1;
	localparam int FAW = $clog2(FD);
	localparam int FCW = $clog2(FD + 1);
	localparam int LAW = $clog2(MAX_LIVE);
	localparam int EW = $bits(ffba_pkg::ext_t);
	localparam logic [LAW-1:0] LAST = LAW'(MAX_LIVE - 1);
	localparam logic [FCW-1:0] FDC = FCW'(FD);
	localparam logic [FCW-1:0] ONE = FCW'(1);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SLOT = 5'd1;
	localparam logic [4:0] S_AF_RD = 5'd2;
	localparam logic [4:0] S_AF_CK = 5'd3;
	localparam logic [4:0] S_RM_RD = 5'd4;
	localparam logic [4:0] S_RM_WR = 5'd5;
	localparam logic [4:0] S_LV_RD = 5'd6;
	localparam logic [4:0] S_LV_CK = 5'd7;
	localparam logic [4:0] S_SU_RD = 5'd8;
	localparam logic [4:0] S_SU_CK = 5'd9;
	localparam logic [4:0] S_PR_INIT = 5'd10;
	localparam logic [4:0] S_PR_RD = 5'd11;
	localparam logic [4:0] S_PR_CK = 5'd12;
	localparam logic [4:0] S_IN_INIT = 5'd13;
	localparam logic [4:0] S_IN_RD = 5'd14;
	localparam logic [4:0] S_IN_CK = 5'd15;
	localparam logic [4:0] S_IS_RD = 5'd16;
	localparam logic [4:0] S_IS_WR = 5'd17;
	localparam logic [4:0] S_SUM_RD = 5'd18;
	localparam logic [4:0] S_SUM_CK = 5'd19;
	localparam logic [4:0] S_CLR = 5'd20;
	localparam logic [4:0] S_OUT = 5'd21;

	logic [4:0] state_q;
	logic [4:0] ret_q;
	logic init_pend_q;
	logic [FCW-1:0] fcnt_q;
	logic [FCW-1:0] fj_q;
	logic [FCW-1:0] ks_q;
	logic [MAX_LIVE-1:0] lvalid_q;
	logic [LAW-1:0] li_q;
	logic [LAW-1:0] slot_q;
	logic [ffba_pkg::LEN_W-1:0] need_q;
	logic [ffba_pkg::BLK_W-1:0] blk_q;
	logic [ffba_pkg::BLK_W-1:0] st_q;
	logic [ffba_pkg::BLK_W-1:0] nstart_q;
	logic [ffba_pkg::LEN_W-1:0] nlen_q;
	logic [ffba_pkg::LEN_W-1:0] len_q;
	logic [ffba_pkg::LEN_W-1:0] total_q;
	logic [2:0] rstat_q;
	logic [ffba_pkg::LEN_W-1:0] rblk_q;

	logic f_we;
	logic [FAW-1:0] f_waddr;
	logic [FAW-1:0] f_raddr;
	logic [EW-1:0] f_wdata;
	logic [EW-1:0] f_rdata;
	logic l_we;
	logic [LAW-1:0] l_waddr;
	logic [LAW-1:0] l_raddr;
	logic [EW-1:0] l_wdata;
	logic [EW-1:0] l_rdata;
	ffba_pkg::ext_t fr;
	ffba_pkg::ext_t lr;
	logic fit;
	logic more;
	logic li_last;
	logic [30:0] off_prod;

	assign fr = ffba_pkg::ext_t'(f_rdata);
	assign lr = ffba_pkg::ext_t'(l_rdata);
	assign fit = fr.len >= need_q;
	assign more = ({1'b0, fj_q} + {1'b0, ONE}) < {1'b0, fcnt_q};
	assign li_last = (li_q == LAST);
	assign cmd_pop = (state_q == S_IDLE) && !init_pend_q && cmd_valid;
	assign res_push = (state_q == S_OUT) && !res_full;
	assign off_prod = st_q * bb6;
	assign res.status = rstat_q;
	assign res.blocks = rblk_q;
	assign res.offset = (rstat_q == ffba_pkg::ST_ALLOCATED) ? {3'b000, off_prod, 6'b000000} : '0;

	ffba_ram #(.W(EW), .DEPTH(FD)) u_free_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	ffba_ram #(.W(EW), .DEPTH(MAX_LIVE)) u_live_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	always_comb begin
		f_we = 1'b0;
		f_waddr = fj_q[FAW-1:0];
		f_wdata = f_rdata;
		f_raddr = fj_q[FAW-1:0];
		l_we = 1'b0;
		l_waddr = slot_q;
		l_wdata = {fr.start, need_q};
		l_raddr = li_q;
		case (state_q)
			S_IDLE: begin
				if (init_pend_q) begin
					f_we = 1'b1;
					f_waddr = '0;
					f_wdata = {{ffba_pkg::BLK_W{1'b0}}, pool};
				end
			end
			S_CLR: begin
				f_we = 1'b1;
				f_waddr = '0;
				f_wdata = {{ffba_pkg::BLK_W{1'b0}}, pool};
			end
			S_AF_CK: begin
				if (fit) begin
					l_we = 1'b1;
					if (fr.len != need_q) begin
						f_we = 1'b1;
						f_wdata = {fr.start + need_q[ffba_pkg::BLK_W-1:0], fr.len - need_q};
					end
				end
			end
			S_RM_RD: f_raddr = FAW'(fj_q + ONE);
			S_RM_WR: f_we = 1'b1;
			S_PR_RD: f_raddr = FAW'(fj_q - ONE);
			S_IS_RD: begin
				if (ks_q > fj_q) begin
					f_raddr = FAW'(ks_q - ONE);
				end else begin
					f_we = 1'b1;
					f_wdata = {nstart_q, nlen_q};
				end
			end
			S_IS_WR: begin
				f_we = 1'b1;
				f_waddr = ks_q[FAW-1:0];
			end
			default: f_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			init_pend_q <= 1'b1;
			fcnt_q <= ONE;
			fj_q <= '0;
			ks_q <= '0;
			lvalid_q <= '0;
			li_q <= '0;
			slot_q <= '0;
			need_q <= '0;
			blk_q <= '0;
			st_q <= '0;
			nstart_q <= '0;
			nlen_q <= '0;
			len_q <= '0;
			total_q <= '0;
			rstat_q <= '0;
			rblk_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (init_pend_q) begin
						fcnt_q <= ONE;
						lvalid_q <= '0;
						init_pend_q <= 1'b0;
					end else if (cmd_valid) begin
						li_q <= '0;
						case (cmd.op)
							ffba_pkg::OP_ALLOC: begin
								need_q <= cmd.arg;
								state_q <= S_SLOT;
							end
							ffba_pkg::OP_FREE: begin
								blk_q <= cmd.arg[ffba_pkg::BLK_W-1:0];
								state_q <= S_LV_RD;
							end
							ffba_pkg::OP_FREE_ALL: begin
								total_q <= '0;
								state_q <= S_SUM_RD;
							end
							default: begin
								rstat_q <= cmd.status;
								rblk_q <= '0;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_SLOT: begin
					if (!lvalid_q[li_q]) begin
						slot_q <= li_q;
						fj_q <= '0;
						state_q <= S_AF_RD;
					end else if (li_last) begin
						rstat_q <= ffba_pkg::ST_TABLE_FULL;
						rblk_q <= '0;
						state_q <= S_OUT;
					end else begin
						li_q <= li_q + LAW'(1);
					end
				end
				S_AF_RD: begin
					if (fj_q == fcnt_q) begin
						rstat_q <= ffba_pkg::ST_NO_MEM;
						rblk_q <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_AF_CK;
					end
				end
				S_AF_CK: begin
					if (fit) begin
						st_q <= fr.start;
						lvalid_q[slot_q] <= 1'b1;
						rstat_q <= ffba_pkg::ST_ALLOCATED;
						rblk_q <= need_q;
						if (fr.len == need_q) begin
							ret_q <= S_OUT;
							state_q <= S_RM_RD;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						fj_q <= fj_q + ONE;
						state_q <= S_AF_RD;
					end
				end
				S_RM_RD: begin
					if (more) begin
						state_q <= S_RM_WR;
					end else begin
						fcnt_q <= fcnt_q - ONE;
						state_q <= ret_q;
					end
				end
				S_RM_WR: begin
					fj_q <= fj_q + ONE;
					state_q <= S_RM_RD;
				end
				S_LV_RD: begin
					if (lvalid_q[li_q]) begin
						state_q <= S_LV_CK;
					end else if (li_last) begin
						rstat_q <= ffba_pkg::ST_NOT_ALLOC;
						rblk_q <= '0;
						state_q <= S_OUT;
					end else begin
						li_q <= li_q + LAW'(1);
					end
				end
				S_LV_CK: begin
					if (lr.start == blk_q) begin
						len_q <= lr.len;
						nlen_q <= lr.len;
						nstart_q <= blk_q;
						lvalid_q[li_q] <= 1'b0;
						fj_q <= '0;
						state_q <= S_SU_RD;
					end else if (li_last) begin
						rstat_q <= ffba_pkg::ST_NOT_ALLOC;
						rblk_q <= '0;
						state_q <= S_OUT;
					end else begin
						li_q <= li_q + LAW'(1);
						state_q <= S_LV_RD;
					end
				end
				S_SU_RD: begin
					if (fj_q == fcnt_q) begin
						state_q <= S_PR_INIT;
					end else begin
						state_q <= S_SU_CK;
					end
				end
				S_SU_CK: begin
					if (fr.start > blk_q) begin
						if (({2'b00, blk_q} + {1'b0, len_q}) == {2'b00, fr.start}) begin
							nlen_q <= nlen_q + fr.len;
							ret_q <= S_PR_INIT;
							state_q <= S_RM_RD;
						end else begin
							state_q <= S_PR_INIT;
						end
					end else begin
						fj_q <= fj_q + ONE;
						state_q <= S_SU_RD;
					end
				end
				S_PR_INIT: begin
					fj_q <= fcnt_q;
					state_q <= S_PR_RD;
				end
				S_PR_RD: begin
					if (fj_q == '0) begin
						state_q <= S_IN_INIT;
					end else begin
						state_q <= S_PR_CK;
					end
				end
				S_PR_CK: begin
					if (fr.start < blk_q) begin
						if (({2'b00, fr.start} + {1'b0, fr.len}) == {2'b00, blk_q}) begin
							nstart_q <= fr.start;
							nlen_q <= nlen_q + fr.len;
							fj_q <= fj_q - ONE;
							ret_q <= S_IN_INIT;
							state_q <= S_RM_RD;
						end else begin
							state_q <= S_IN_INIT;
						end
					end else begin
						fj_q <= fj_q - ONE;
						state_q <= S_PR_RD;
					end
				end
				S_IN_INIT: begin
					if (fcnt_q >= FDC) begin
						rstat_q <= ffba_pkg::ST_FREED;
						rblk_q <= len_q;
						state_q <= S_OUT;
					end else begin
						fj_q <= '0;
						state_q <= S_IN_RD;
					end
				end
				S_IN_RD: begin
					if (fj_q == fcnt_q) begin
						ks_q <= fcnt_q;
						state_q <= S_IS_RD;
					end else begin
						state_q <= S_IN_CK;
					end
				end
				S_IN_CK: begin
					if (fr.start < nstart_q) begin
						fj_q <= fj_q + ONE;
						state_q <= S_IN_RD;
					end else begin
						ks_q <= fcnt_q;
						state_q <= S_IS_RD;
					end
				end
				S_IS_RD: begin
					if (ks_q > fj_q) begin
						state_q <= S_IS_WR;
					end else begin
						fcnt_q <= fcnt_q + ONE;
						rstat_q <= ffba_pkg::ST_FREED;
						rblk_q <= len_q;
						state_q <= S_OUT;
					end
				end
				S_IS_WR: begin
					ks_q <= ks_q - ONE;
					state_q <= S_IS_RD;
				end
				S_SUM_RD: begin
					if (lvalid_q[li_q]) begin
						state_q <= S_SUM_CK;
					end else if (li_last) begin
						state_q <= S_CLR;
					end else begin
						li_q <= li_q + LAW'(1);
					end
				end
				S_SUM_CK: begin
					total_q <= total_q + lr.len;
					if (li_last) begin
						state_q <= S_CLR;
					end else begin
						li_q <= li_q + LAW'(1);
						state_q <= S_SUM_RD;
					end
				end
				S_CLR: begin
					fcnt_q <= ONE;
					lvalid_q <= '0;
					rstat_q <= ffba_pkg::ST_ALL_FREED;
					rblk_q <= total_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (init) begin
				init_pend_q <= 1'b1;
			end
		end
	end

	`FFBA_ASSERT_NEVER(a_fcnt_range, fcnt_q > FDC, "free extent count out of range")
	`FFBA_ASSERT(a_slot_taken, (state_q == S_AF_CK && fit) |=> lvalid_q[$past(slot_q)], "granted slot not marked live")
	`FFBA_ASSERT(a_remove_shrinks, (state_q == S_RM_RD && !more) |=> (fcnt_q == $past(fcnt_q) - ONE), "extent removal did not shrink the table")

endmodule

// ===== rtl/first_fit_block_allocator_core.sv =====
// first fit block allocator top level
//
// channel   direction  handshake          payload
// request   in         push / full        func, request_bytes, release_offset
// result    out        pop / empty        status, grant_offset, grant_blocks
// config    in         cfg_we             cfg_index, cfg_wdata
//
// front end takes one quotient bit per cycle of the shared divider and takes no new request until the last is queued
// back end walks the live and free tables one entry at a time
// a free walks the live table, then the free table up to six times (merge search and removal, insert search and shift)
// after reset and after each block bytes or pool blocks write the free table is re-seeded once the back end is idle
// a full result queue stalls the back end; a full command queue stalls the front end
module first_fit_block_allocator_core #(
	parameter int MAX_LIVE = 64,
	parameter int MAX_BLOCKS = 65536
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [1:0]                           func,
	input  logic [ffba_pkg::OFF_W-1:0]           request_bytes,
	input  logic [ffba_pkg::OFF_W-1:0]           release_offset,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [2:0]                           status,
	output logic [ffba_pkg::OFF_W-1:0]           grant_offset,
	output logic [ffba_pkg::LEN_W-1:0]           grant_blocks,
	input  logic                                 cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ffba_pkg::BB_W-1:0]            cfg_wdata
);

	logic [ffba_pkg::BB_W-1:0] block_bytes_q;
	logic [ffba_pkg::LEN_W-1:0] pool_blocks_q;
	logic [ffba_pkg::BB6_W-1:0] bb6;
	logic [ffba_pkg::LEN_W-1:0] pool;
	logic init;
	logic cq_push;
	logic cq_full;
	logic cq_empty;
	logic cq_pop;
	ffba_pkg::cmd_t cq_in;
	ffba_pkg::cmd_t cq_out;
	logic rq_push;
	logic rq_full;
	ffba_pkg::res_t rq_in;
	ffba_pkg::res_t rq_out;

	assign init = cfg_we && (cfg_index == ffba_pkg::CFG_BLOCK_BYTES
		|| cfg_index == ffba_pkg::CFG_POOL_BLOCKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= 21'd64;
			pool_blocks_q <= 17'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				ffba_pkg::CFG_BLOCK_BYTES: block_bytes_q <= cfg_wdata;
				ffba_pkg::CFG_POOL_BLOCKS: pool_blocks_q <= cfg_wdata[ffba_pkg::LEN_W-1:0];
				default: block_bytes_q <= block_bytes_q;
			endcase
		end
	end

	always_comb begin
		bb6 = block_bytes_q[ffba_pkg::BB_W-1:6];
		if (bb6 == '0) begin
			bb6 = ffba_pkg::BB6_W'(1);
		end
		pool = pool_blocks_q;
		if (pool == '0) begin
			pool = ffba_pkg::LEN_W'(1);
		end
		if (32'(pool) > 32'(MAX_BLOCKS)) begin
			pool = ffba_pkg::LEN_W'(MAX_BLOCKS);
		end
	end

	ffba_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.func           (func),
		.request_bytes  (request_bytes),
		.release_offset (release_offset),
		.bb6            (bb6),
		.pool           (pool),
		.cq_push        (cq_push),
		.cq_cmd         (cq_in),
		.cq_full        (cq_full)
	);

	ffba_queue #(.W($bits(ffba_pkg::cmd_t))) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.din    (cq_in),
		.full   (cq_full),
		.pop    (cq_pop),
		.dout   (cq_out),
		.empty  (cq_empty)
	);

	ffba_back #(.MAX_LIVE(MAX_LIVE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.init      (init),
		.bb6       (bb6),
		.pool      (pool),
		.cmd_valid (!cq_empty),
		.cmd       (cq_out),
		.cmd_pop   (cq_pop),
		.res_full  (rq_full),
		.res_push  (rq_push),
		.res       (rq_in)
	);

	ffba_queue #(.W($bits(ffba_pkg::res_t))) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.din    (rq_in),
		.full   (rq_full),
		.pop    (pop),
		.dout   (rq_out),
		.empty  (empty)
	);

	assign status = rq_out.status;
	assign grant_offset = rq_out.offset;
	assign grant_blocks = rq_out.blocks;

endmodule
